// ----- src/ssao_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssao_pkg: shared types and constants of the speed and angle observer
// Operand and product types of the shared multiplier, the sequencer states and
// step codes, register indexes, fixed-point constants and saturation helpers.
// ----------------------------------------------------------------------------
package ssao_pkg;

    localparam int MW     = 33;   // multiplier operand width, signed
    localparam int PW     = 66;   // multiplier product width, signed
    localparam int DIV_W  = 41;   // magnitude of the speed numerator
    localparam int FLUX_W = 24;

    localparam int SIN_C1      = 51472;
    localparam int SIN_C2      = 21024;
    localparam int SIN_C3      = 2320;
    localparam int INV_TWO_PI  = 170891319;
    localparam int FILT_K      = 4294967;
    localparam int SPEED_LIMIT = 128000;
    localparam int G_MAX       = 268435456;

    typedef logic signed [MW-1:0] mop_t;
    typedef logic signed [PW-1:0] prod_t;

    typedef enum logic [2:0] {
        REG_RES    = 3'd0,
        REG_IND    = 3'd1,
        REG_FLUX   = 3'd2,
        REG_GAIN   = 3'd3,
        REG_LAMBDA = 3'd4,
        REG_INJ    = 3'd5,
        REG_TS     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    // Each step issues one product and stores the product of the step before.
    typedef enum logic [5:0] {
        S_SQ_S, S_SQ_C, S_IN_S, S_IN_C, S_PO_S, S_PO_C, S_SN, S_CS,
        S_WL, S_RD, S_RQ, S_WHQ, S_WLQ, S_WHD, S_WLD, S_EDL,
        S_AWL, S_REF, S_GTS, S_FLT, S_PVD0, S_PVD1, S_PVQ0, S_PVQ1,
        S_PID0, S_PID1, S_PIQ0, S_PIQ1, S_PIQ2, S_UPD, S_SPD, S_TRN,
        S_P48, S_TH, S_TL, S_ANG
    } step_t;

    typedef struct packed {
        logic  in_ready;
        logic  go;
        logic  emit;
        step_t step;
    } ctrl_t;

    // Folds a 16-bit turn fraction onto the quarter wave, result in Q14.
    function automatic logic signed [15:0] fold(input logic [15:0] u);
        logic signed [16:0] s;
        s = $signed({u[15], u});
        if (s > 17'sd16384)
            s = 17'sd32768 - s;
        else if (s < -17'sd16384)
            s = -17'sd32768 - s;
        return s[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input prod_t v);
        if (v > prod_t'(32767))
            return 16'sh7FFF;
        else if (v < -prod_t'(32768))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input prod_t v);
        if (v > prod_t'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        else if (v < -prod_t'(33'sh080000000))
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/ssao_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssao_mul: shared signed multiplier
// One signed 33 by 33 product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module ssao_mul
    import ssao_pkg::*;
(
    input  logic  clk,
    input  mop_t  a,
    input  mop_t  b,
    output prod_t p
);

    prod_t p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ----- src/ssao_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssao_div: serial unsigned divider
// Restoring division, one quotient bit per cycle, for the flux division.
// ----------------------------------------------------------------------------
module ssao_div
    import ssao_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [FLUX_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CW = $clog2(DIV_W);

    logic              busy_reg;
    logic [CW-1:0]     cnt_reg;
    logic [FLUX_W-1:0] rem_reg;
    logic [FLUX_W-1:0] dsr_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [FLUX_W:0]   shifted;
    logic [FLUX_W+1:0] trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[FLUX_W+1])
            begin
                rem_reg <= trial[FLUX_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[FLUX_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ----- src/ssao_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssao_ctrl: observer sequencer
// Walks the step program once per item, waits for the divider before the
// speed update, and holds the result until the output register is free.
// ----------------------------------------------------------------------------
module ssao_ctrl
    import ssao_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  div_busy,
    input  logic  out_hold,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   div_wait;

    assign div_wait = (step_reg == S_UPD) && div_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= S_SQ_S;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC;
                    step_next  = S_SQ_S;
                end
            end
            ST_CALC:
            begin
                if (!div_wait)
                begin
                    if (step_reg == S_ANG)
                        state_next = ST_EMIT;
                    else
                        step_next = step_t'(step_reg + 6'd1);
                end
            end
            ST_EMIT:
            begin
                if (!out_hold)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.go       = (state_reg == ST_CALC) && !div_wait;
        ctrl.emit     = (state_reg == ST_EMIT) && !out_hold;
        ctrl.step     = step_reg;
    end

endmodule
`default_nettype wire

// ----- src/pmsm_sensorless_speed_angle_observer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pmsm_sensorless_speed_angle_observer_unit: sensorless PMSM observer
// Voltage-model back-EMF, speed and angle estimation with d-current injection.
//
// Input channel (in_valid/in_ready) carries one beat of alpha/beta voltages
// and currents per PWM period. Output channel (out_valid/out_ready) returns
// one beat of speed, angle, id reference and d/q back-EMF per input beat.
// Configuration writes come on cfg_valid/cfg_ready with a register index and
// data; cfg_ready is always high and writes are expected while idle.
//
// One shared multiplier runs a 36-step program; the speed numerator goes to a
// 41-bit serial divider started at step 17, and the program waits for it
// before the speed update. A new beat is taken only once the previous item
// has finished its program and been handed to the output register.
// A finished result sits in the output register; the next beat is accepted
// meanwhile, and that item stalls only at its final step while the previous
// result is still waiting. Reset loads the register defaults and clears the
// speed, angle, filter and stored d/q values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pmsm_sensorless_speed_angle_observer_unit
    import ssao_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] volt_alpha,
    input  logic signed [15:0] volt_beta,
    input  logic signed [15:0] curr_alpha,
    input  logic signed [15:0] curr_beta,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] speed_est,
    output logic        [15:0] angle_est,
    output logic signed [15:0] id_injection,
    output logic signed [15:0] emf_d,
    output logic signed [15:0] emf_q,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data
);

    localparam int RND_BIT  = 53 - ANGLE_BITS;
    localparam int TURN_LSB = 54 - ANGLE_BITS;

    // configuration
    logic [19:0] res_reg;
    logic [23:0] ind_reg;
    logic [23:0] flux_reg;
    logic [15:0] bgain_reg;
    logic [16:0] lam_reg;
    logic [17:0] inj_reg;
    logic [31:0] ts_reg;

    // observer state
    logic signed [31:0]     w_reg;
    logic [ANGLE_BITS-1:0]  ang_reg;
    logic signed [31:0]     filt_reg;
    logic signed [15:0]     pvd_reg, pvq_reg, pid_reg, piq_reg;

    // input beat
    logic signed [15:0] va_reg, vb_reg, ia_reg, ib_reg;

    // intermediates
    logic signed [15:0] x2s_reg, x2c_reg, inner_s_reg, inner_c_reg;
    logic signed [16:0] poly_s_reg, poly_c_reg, sin_reg, cos_reg;
    logic signed [40:0] wl_reg;
    logic signed [57:0] accd_reg, accq_reg;
    logic signed [42:0] num_reg;
    logic        [30:0] alpha_reg;
    logic signed [31:0] ref_reg;
    logic        [28:0] gr_reg;
    logic signed [33:0] pacc_reg;
    logic signed [47:0] p48_reg;
    logic        [63:0] tacc_reg;

    // outputs
    logic               out_valid_reg;
    logic signed [31:0] speed_out_reg;
    logic        [15:0] angle_out_reg;
    logic signed [15:0] id_out_reg, ed_out_reg, eq_out_reg;

    ctrl_t              ctrl;
    mop_t               mul_a, mul_b;
    prod_t              prod;
    logic               div_busy, div_start;
    logic [DIV_W-1:0]   div_q;
    logic [DIV_W-1:0]   div_n;
    logic [FLUX_W-1:0]  flux_eff;
    logic [15:0]        a16;
    logic signed [15:0] xs, xc;
    logic               sign_pos;
    logic [31:0]        absw;
    logic signed [15:0] ed_w, eq_w;
    logic signed [31:0] wr_w;
    prod_t              num_abs;
    prod_t              wr_full;
    logic [63:0]        turn_sum;
    logic [63:0]        turn_rnd;

    generate
        if (ANGLE_BITS >= 16)
        begin : g_ang_wide
            assign a16 = ang_reg[ANGLE_BITS-1 -: 16];
        end
        else
        begin : g_ang_narrow
            assign a16 = {ang_reg, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign xs       = fold(a16);
    assign xc       = fold(a16 + 16'd16384);
    assign sign_pos = !w_reg[31] && (w_reg != 32'sd0);
    assign absw     = w_reg[31] ? unsigned'(-w_reg) : unsigned'(w_reg);
    assign ed_w     = sat16((prod_t'(accd_reg) + prod_t'(32768)) >>> 16);
    assign eq_w     = sat16((prod_t'(accq_reg) + prod_t'(32768)) >>> 16);
    assign num_abs  = num_reg[42] ? -prod_t'(num_reg) : prod_t'(num_reg);
    assign div_n    = num_abs[DIV_W-1:0];
    assign flux_eff = (flux_reg == '0) ? FLUX_W'(1) : flux_reg;
    assign wr_full  = num_reg[42] ? -prod_t'(div_q) : prod_t'(div_q);
    assign wr_w     = sat32(wr_full);
    assign turn_sum = tacc_reg + prod[63:0];
    assign turn_rnd = turn_sum + (64'd1 << RND_BIT);
    assign div_start = ctrl.go && (ctrl.step == S_REF);

    ssao_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .div_busy (div_busy),
        .out_hold (out_valid_reg && !out_ready),
        .ctrl     (ctrl)
    );

    ssao_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    ssao_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (flux_eff),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Operand selection for the product issued in the current step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.step)
            S_SQ_S:
            begin
                mul_a = mop_t'(xs);
                mul_b = mop_t'(xs);
            end
            S_SQ_C:
            begin
                mul_a = mop_t'(xc);
                mul_b = mop_t'(xc);
            end
            S_IN_S:
            begin
                mul_a = mop_t'(x2s_reg);
                mul_b = mop_t'(SIN_C3);
            end
            S_IN_C:
            begin
                mul_a = mop_t'(x2c_reg);
                mul_b = mop_t'(SIN_C3);
            end
            S_PO_S:
            begin
                mul_a = mop_t'(x2s_reg);
                mul_b = mop_t'(inner_s_reg);
            end
            S_PO_C:
            begin
                mul_a = mop_t'(x2c_reg);
                mul_b = mop_t'(inner_c_reg);
            end
            S_SN:
            begin
                mul_a = mop_t'(xs);
                mul_b = mop_t'(poly_s_reg);
            end
            S_CS:
            begin
                mul_a = mop_t'(xc);
                mul_b = mop_t'(poly_c_reg);
            end
            S_WL:
            begin
                mul_a = mop_t'(w_reg);
                mul_b = mop_t'(ind_reg);
            end
            S_RD:
            begin
                mul_a = mop_t'(res_reg);
                mul_b = mop_t'(pid_reg);
            end
            S_RQ:
            begin
                mul_a = mop_t'(res_reg);
                mul_b = mop_t'(piq_reg);
            end
            S_WHQ:
            begin
                mul_a = mop_t'($signed(wl_reg[40:16]));
                mul_b = mop_t'(piq_reg);
            end
            S_WLQ:
            begin
                mul_a = mop_t'(wl_reg[15:0]);
                mul_b = mop_t'(piq_reg);
            end
            S_WHD:
            begin
                mul_a = mop_t'($signed(wl_reg[40:16]));
                mul_b = mop_t'(pid_reg);
            end
            S_WLD:
            begin
                mul_a = mop_t'(wl_reg[15:0]);
                mul_b = mop_t'(pid_reg);
            end
            S_EDL:
            begin
                mul_a = mop_t'(ed_w);
                mul_b = mop_t'(lam_reg);
            end
            S_AWL:
            begin
                mul_a = mop_t'(absw);
                mul_b = mop_t'(lam_reg);
            end
            S_REF:
            begin
                mul_a = mop_t'(piq_reg);
                mul_b = mop_t'(inj_reg);
            end
            S_GTS:
            begin
                mul_a = mop_t'(alpha_reg);
                mul_b = mop_t'(ts_reg);
            end
            S_FLT:
            begin
                mul_a = mop_t'(prod_t'(ref_reg) - prod_t'(filt_reg));
                mul_b = mop_t'(FILT_K);
            end
            S_PVD0:
            begin
                mul_a = mop_t'(cos_reg);
                mul_b = mop_t'(va_reg);
            end
            S_PVD1:
            begin
                mul_a = mop_t'(sin_reg);
                mul_b = mop_t'(vb_reg);
            end
            S_PVQ0:
            begin
                mul_a = mop_t'(cos_reg);
                mul_b = mop_t'(vb_reg);
            end
            S_PVQ1:
            begin
                mul_a = mop_t'(sin_reg);
                mul_b = mop_t'(va_reg);
            end
            S_PID0:
            begin
                mul_a = mop_t'(cos_reg);
                mul_b = mop_t'(ia_reg);
            end
            S_PID1:
            begin
                mul_a = mop_t'(sin_reg);
                mul_b = mop_t'(ib_reg);
            end
            S_PIQ0:
            begin
                mul_a = mop_t'(cos_reg);
                mul_b = mop_t'(ib_reg);
            end
            S_PIQ1:
            begin
                mul_a = mop_t'(sin_reg);
                mul_b = mop_t'(ia_reg);
            end
            S_UPD:
            begin
                mul_a = mop_t'(gr_reg);
                mul_b = mop_t'(prod_t'(wr_w) - prod_t'(w_reg));
            end
            S_TRN:
            begin
                mul_a = mop_t'(w_reg);
                mul_b = mop_t'(ts_reg);
            end
            S_TH:
            begin
                mul_a = mop_t'($signed(p48_reg[47:24]));
                mul_b = mop_t'(INV_TWO_PI);
            end
            S_TL:
            begin
                mul_a = mop_t'(p48_reg[23:0]);
                mul_b = mop_t'(INV_TWO_PI);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            va_reg <= volt_alpha;
            vb_reg <= volt_beta;
            ia_reg <= curr_alpha;
            ib_reg <= curr_beta;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg   <= 20'd0;
            ind_reg   <= 24'd0;
            flux_reg  <= 24'd1;
            bgain_reg <= 16'd1500;
            lam_reg   <= 17'd64881;
            inj_reg   <= 18'd52429;
            ts_reg    <= 32'd214748;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RES:    res_reg   <= cfg_data[19:0];
                REG_IND:    ind_reg   <= cfg_data[23:0];
                REG_FLUX:   flux_reg  <= cfg_data[23:0];
                REG_GAIN:   bgain_reg <= cfg_data[15:0];
                REG_LAMBDA: lam_reg   <= cfg_data[16:0];
                REG_INJ:    inj_reg   <= cfg_data[17:0];
                REG_TS:     ts_reg    <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Observer state, written by the step program.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= '0;
            ang_reg  <= '0;
            filt_reg <= '0;
            pvd_reg  <= '0;
            pvq_reg  <= '0;
            pid_reg  <= '0;
            piq_reg  <= '0;
        end
        else if (ctrl.go)
        begin
            unique case (ctrl.step)
                S_PVD0:
                begin
                    if (absw > SPEED_LIMIT)
                        filt_reg <= '0;
                    else
                        filt_reg <= 32'(prod_t'(filt_reg)
                                       + ((prod + prod_t'(33'sh080000000)) >>> 32));
                end
                S_PVQ0: pvd_reg <= sat16((prod_t'(pacc_reg) + prod + prod_t'(16384)) >>> 15);
                S_PID0: pvq_reg <= sat16((prod_t'(pacc_reg) - prod + prod_t'(16384)) >>> 15);
                S_PIQ0: pid_reg <= sat16((prod_t'(pacc_reg) + prod + prod_t'(16384)) >>> 15);
                S_PIQ2: piq_reg <= sat16((prod_t'(pacc_reg) - prod + prod_t'(16384)) >>> 15);
                S_SPD:  w_reg   <= sat32(prod_t'(w_reg) + ((prod + prod_t'(524288)) >>> 20));
                S_ANG:  ang_reg <= ang_reg + turn_rnd[53:TURN_LSB];
                default: ;
            endcase
        end
    end

    // Intermediate values of the step program.
    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            unique case (ctrl.step)
                S_SQ_C: x2s_reg     <= 16'(prod >>> 14);
                S_IN_S: x2c_reg     <= 16'(prod >>> 14);
                S_IN_C: inner_s_reg <= 16'(prod_t'(SIN_C2) - (prod >>> 14));
                S_PO_S: inner_c_reg <= 16'(prod_t'(SIN_C2) - (prod >>> 14));
                S_PO_C: poly_s_reg  <= 17'(prod_t'(SIN_C1) - (prod >>> 14));
                S_SN:   poly_c_reg  <= 17'(prod_t'(SIN_C1) - (prod >>> 14));
                S_CS:   sin_reg     <= 17'(prod >>> 14);
                S_WL:   cos_reg     <= 17'(prod >>> 14);
                S_RD:   wl_reg      <= 41'((prod + prod_t'(32768)) >>> 16);
                S_RQ:   accd_reg    <= 58'((prod_t'(pvd_reg) <<< 16) - prod);
                S_WHQ:  accq_reg    <= 58'((prod_t'(pvq_reg) <<< 16) - prod);
                S_WLQ:  accd_reg    <= 58'(prod_t'(accd_reg) + (prod <<< 16));
                S_WHD:  accd_reg    <= 58'(prod_t'(accd_reg) + prod);
                S_WLD:  accq_reg    <= 58'(prod_t'(accq_reg) - (prod <<< 16));
                S_EDL:  accq_reg    <= 58'(prod_t'(accq_reg) - prod);
                S_AWL:
                begin
                    // Zero speed takes the negative sign, so the coupling term adds.
                    num_reg <= 43'(((prod_t'(eq_w) <<< 16) - (sign_pos ? prod : -prod)) <<< 8);
                end
                S_REF:
                begin
                    alpha_reg <= 31'(prod_t'({bgain_reg, 4'b0000})
                                     + ((prod + prod_t'(262144)) >>> 19));
                end
                S_GTS:  ref_reg <= sat32(sign_pos ? prod : -prod);
                S_FLT:
                begin
                    if (((prod + prod_t'(32768)) >>> 16) > prod_t'(G_MAX))
                        gr_reg <= 29'(G_MAX);
                    else
                        gr_reg <= 29'((prod + prod_t'(32768)) >>> 16);
                end
                S_PVD1: pacc_reg <= 34'(prod);
                S_PVQ1: pacc_reg <= 34'(prod);
                S_PID1: pacc_reg <= 34'(prod);
                S_PIQ1: pacc_reg <= 34'(prod);
                S_P48:  p48_reg  <= 48'((prod + prod_t'(32768)) >>> 16);
                S_TL:   tacc_reg <= {prod[39:0], 24'd0};
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            speed_out_reg <= w_reg;
            angle_out_reg <= a16;
            id_out_reg    <= sat16((prod_t'(filt_reg) + prod_t'(32768)) >>> 16);
            ed_out_reg    <= ed_w;
            eq_out_reg    <= eq_w;
        end
    end

    assign in_ready     = ctrl.in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign speed_est    = speed_out_reg;
    assign angle_est    = angle_out_reg;
    assign id_injection = id_out_reg;
    assign emf_d        = ed_out_reg;
    assign emf_q        = eq_out_reg;

    a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !div_busy)
        else $error("input beat taken while the divider is still running");

    a_start_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while an item is in work");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> out_valid)
        else $error("result emitted but output not valid");

endmodule
`default_nettype wire

// ----- tb/sv/ssao_checker.sv -----
// ----------------------------------------------------------------------------
// ssao_checker: result predictor and scoreboard for the speed/angle observer
// Watches the configuration, input and output channels, runs a bit-exact
// model of the observer on every accepted input beat and compares each
// output beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module ssao_checker
    import ssao_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] volt_alpha,
    input  logic signed [15:0] volt_beta,
    input  logic signed [15:0] curr_alpha,
    input  logic signed [15:0] curr_beta,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] speed_est,
    input  logic        [15:0] angle_est,
    input  logic signed [15:0] id_injection,
    input  logic signed [15:0] emf_d,
    input  logic signed [15:0] emf_q,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [31:0] cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    typedef struct {
        logic signed [31:0] speed;
        logic        [15:0] angle;
        logic signed [15:0] id_ref;
        logic signed [15:0] ed;
        logic signed [15:0] eq;
    } estimate_t;

    estimate_t estimates[$];

    longint res_r, ind_r, flux_r, gain_r, lam_r, inj_r, ts_r;
    longint spd_r, filt_r, pvd, pvq, pid, piq;
    longint unsigned ang_r;

    function automatic longint asr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint rnd(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint sine_q15(input logic [15:0] u);
        longint s;
        longint x2;
        longint inner;
        longint poly;
        s = longint'(u);
        if (s >= 32768)
            s -= 65536;
        if (s > 16384)
            s = 32768 - s;
        else if (s < -16384)
            s = -32768 - s;
        x2 = asr(s * s, 14);
        inner = 21024 - asr(x2 * 2320, 14);
        poly = 51472 - asr(x2 * inner, 14);
        return asr(s * poly, 14);
    endfunction

    function automatic logic [15:0] top_angle(input longint unsigned a);
        if (ANGLE_BITS >= 16)
            return 16'(a >> (ANGLE_BITS - 16));
        else
            return 16'(a << (16 - ANGLE_BITS));
    endfunction

    task automatic load_defaults();
        res_r = 0; ind_r = 0; flux_r = 1; gain_r = 1500;
        lam_r = 64881; inj_r = 52429; ts_r = 214748;
        spd_r = 0; ang_r = 0; filt_r = 0;
        pvd = 0; pvq = 0; pid = 0; piq = 0;
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [31:0] d);
        case (idx)
            REG_RES:    res_r  = d[19:0];
            REG_IND:    ind_r  = d[23:0];
            REG_FLUX:   flux_r = d[23:0];
            REG_GAIN:   gain_r = d[15:0];
            REG_LAMBDA: lam_r  = d[16:0];
            REG_INJ:    inj_r  = d[17:0];
            REG_TS:     ts_r   = d;
            default: ;
        endcase
    endtask

    task automatic observe_step(input longint va, input longint vb,
                                input longint ia, input longint ib);
        longint w, sgn, absw, flux, s, c, wl, ed, eq, wr, alpha, g, ref_i;
        longint unsigned turn;
        logic [15:0] a16;
        estimate_t e;
        w = spd_r;
        sgn = w > 0 ? 1 : -1;
        absw = w < 0 ? -w : w;
        flux = flux_r != 0 ? flux_r : 1;
        a16 = top_angle(ang_r);
        if (absw > SPEED_LIMIT)
            filt_r = 0;
        else begin
            ref_i = clamp(sgn * piq * inj_r, 32);
            filt_r += rnd((ref_i - filt_r) * FILT_K, 32);
        end
        s = sine_q15(a16);
        c = sine_q15(a16 + 16'd16384);
        wl = rnd(w * ind_r, 16);
        ed = clamp(rnd(pvd * 65536 - res_r * pid + wl * piq, 16), 16);
        eq = clamp(rnd(pvq * 65536 - res_r * piq - wl * pid, 16), 16);
        alpha = gain_r * 16 + rnd(2 * lam_r * absw, 20);
        // Division truncates toward zero, as the hardware divider does.
        wr = clamp(((eq * 65536 - sgn * ed * lam_r) * 256) / flux, 32);
        g = rnd(alpha * ts_r, 16);
        if (g > G_MAX)
            g = G_MAX;
        w = clamp(w + rnd(g * (wr - w), 20), 32);
        spd_r = w;
        turn = longint'(unsigned'(rnd(w * ts_r, 16))) * longint'(INV_TWO_PI);
        turn = (turn + (64'd1 << (53 - ANGLE_BITS))) >> (54 - ANGLE_BITS);
        ang_r = (ang_r + turn) & ((64'd1 << ANGLE_BITS) - 1);
        pvd = clamp(rnd(c * va + s * vb, 15), 16);
        pvq = clamp(rnd(c * vb - s * va, 15), 16);
        pid = clamp(rnd(c * ia + s * ib, 15), 16);
        piq = clamp(rnd(c * ib - s * ia, 15), 16);
        e.speed = 32'(w);
        e.angle = top_angle(ang_r);
        e.id_ref = 16'(clamp(rnd(filt_r, 16), 16));
        e.ed = 16'(ed);
        e.eq = 16'(eq);
        estimates.push_back(e);
    endtask

    task automatic compare_result();
        estimate_t e;
        if (estimates.size() == 0) begin
            $error("output beat with no prediction waiting");
            fail_count++;
            return;
        end
        e = estimates.pop_front();
        if (speed_est !== e.speed) begin
            $error("speed_est expected %0d actual %0d", e.speed, speed_est);
            fail_count++;
        end
        if (angle_est !== e.angle) begin
            $error("angle_est expected %0d actual %0d", e.angle, angle_est);
            fail_count++;
        end
        if (id_injection !== e.id_ref) begin
            $error("id_injection expected %0d actual %0d", e.id_ref, id_injection);
            fail_count++;
        end
        if (emf_d !== e.ed) begin
            $error("emf_d expected %0d actual %0d", e.ed, emf_d);
            fail_count++;
        end
        if (emf_q !== e.eq) begin
            $error("emf_q expected %0d actual %0d", e.eq, emf_q);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        results_seen = 0;
        load_defaults();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            load_defaults();
            estimates.delete();
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                write_register(reg_idx_t'(cfg_index), cfg_data);
            // The output beat belongs to an earlier input, so check it first.
            if (out_valid && out_ready) begin
                compare_result();
                results_seen <= results_seen + 1;
            end
            if (in_valid && in_ready)
                observe_step(volt_alpha, volt_beta, curr_alpha, curr_beta);
            pending <= estimates.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top of the sensorless speed and angle observer
// Drives configuration phases, directed and random beats with bursty input
// and a stalling receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
    import ssao_pkg::*;
();

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
    logic signed [15:0] curr_alpha;
    logic signed [15:0] curr_beta;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] speed_est;
    logic        [15:0] angle_est;
    logic signed [15:0] id_injection;
    logic signed [15:0] emf_d;
    logic signed [15:0] emf_q;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [2:0]  cfg_index;
    logic        [31:0] cfg_data;
    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 beats_sent;
    int                 idle_cycles;
    int                 stall_mode;

    pmsm_sensorless_speed_angle_observer_unit dut (.*);
    ssao_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver stall pattern: its style changes from phase to phase.
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(3, 0) != 0);
            2: out_ready <= ($urandom_range(1, 0) != 0);
            default: out_ready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic [15:0] va, input logic [15:0] vb,
                             input logic [15:0] ia, input logic [15:0] ib);
        in_valid   <= 1'b1;
        volt_alpha <= va;
        volt_beta  <= vb;
        curr_alpha <= ia;
        curr_beta  <= ib;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Valid stays high across back-to-back writes; the caller drops it.
    task automatic write_cfg(input reg_idx_t idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || (in_valid && !in_ready))
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_machine(input logic [31:0] r, input logic [31:0] l,
                               input logic [31:0] f, input logic [31:0] g,
                               input logic [31:0] lam, input logic [31:0] inj,
                               input logic [31:0] ts);
        write_cfg(REG_RES, r);
        write_cfg(REG_IND, l);
        write_cfg(REG_FLUX, f);
        write_cfg(REG_GAIN, g);
        write_cfg(REG_LAMBDA, lam);
        write_cfg(REG_INJ, inj);
        write_cfg(REG_TS, ts);
        cfg_valid <= 1'b0;
    endtask

    // Most beats carry bounded random voltages and currents; about one beat in
    // ten is full-range noise.
    task automatic random_phase(input int count);
        int burst;
        logic [15:0] va, vb, ia, ib;
        burst = 0;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                va = 16'($urandom);
                vb = 16'($urandom);
                ia = 16'($urandom);
                ib = 16'($urandom);
            end
            else
            begin
                va = 16'($signed($urandom_range(4000, 0)) - 2000);
                vb = 16'($signed($urandom_range(4000, 0)) - 2000);
                ia = 16'($signed($urandom_range(1000, 0)) - 500);
                ib = 16'($signed($urandom_range(1000, 0)) - 500);
            end
            if (burst == 0)
            begin
                idle_gap($urandom_range(90, 0));
                burst = $urandom_range(12, 1);
            end
            send_beat(va, vb, ia, ib);
            burst--;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        volt_alpha = '0;
        volt_beta = '0;
        curr_alpha = '0;
        curr_beta = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        beats_sent = 0;
        idle_cycles = 0;
        stall_mode = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and zero speed under default settings.
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_beat(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        send_beat(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF);
        drain();

        // Zero flux, zero sample period, register maximums and bits above width.
        set_machine(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFF,
                    32'h1FFFF, 32'h3FFFF, 32'h0);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_beat(16'h8000, 16'h7FFF, 16'h1234, 16'hEDCB);
        send_beat(16'h0100, 16'h0100, 16'h0100, 16'h0100);
        drain();
        set_machine(32'hFFFFF, 32'hFFFFFF, 32'h1, 32'hFFFF,
                    32'h10000, 32'h20000, 32'hFFFFFFFF);
        send_beat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // Random phases across several machine settings and receiver styles.
        for (int p = 0; p < 8; p++)
        begin
            stall_mode = p % 4;
            case (p)
                0: set_machine(0, 0, 1, 1500, 64881, 52429, 214748);
                1: set_machine(32'd3277, 32'd2000, 32'd150000, 1500, 64881,
                               52429, 214748);
                2: set_machine($urandom, $urandom, $urandom_range(32'hFFFFFF, 1),
                               $urandom, $urandom_range(65536, 0),
                               $urandom_range(131072, 0), $urandom);
                3: set_machine(32'd6554, 32'd500, 32'hFFFFFF, 0, 0, 0, 32'd1);
                4: set_machine(32'd1000, 32'd3000, 32'd80000, 3000, 65536,
                               131072, 32'd429497);
                default: set_machine($urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom);
            endcase
            random_phase(155);
            drain();
        end

        $display("Sent %0d input beats, checked %0d results over eleven settings,",
                 beats_sent, results_seen);
        $display("including zero flux, zero step time and register extremes.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ssao_pkg.sv
src/ssao_mul.sv
src/ssao_div.sv
src/ssao_ctrl.sv
src/pmsm_sensorless_speed_angle_observer_unit.sv
tb/sv/ssao_checker.sv
tb/sv/tb.sv
